@@ hdl/lgr_pkg.sv @@
// Shared types, constants and helpers for the Life row stream block.
package lgr_pkg;

  localparam int unsigned COLS      = 64;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned NCOUNT_W  = 4;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [NCOUNT_W-1:0] BIRTH_COUNT   = NCOUNT_W'(3);
  localparam logic [NCOUNT_W-1:0] SURVIVE_COUNT = NCOUNT_W'(2);
  localparam logic [CFG_W-1:0]    COLS_RESET    = CFG_W'(COLS);

  typedef logic [COLS-1:0] row_t;

  typedef struct packed {
    row_t row;
    logic eof;
  } lgr_res_t;

  typedef struct packed {
    logic     push0;
    logic     push1;
    lgr_res_t res0;
    lgr_res_t res1;
  } lgr_push_t;

  function automatic row_t col_mask(input logic [CFG_W-1:0] ncols);
    logic [CFG_W-1:0] n;
    row_t             m;
    n = ncols;
    if (n == '0) begin
      n = CFG_W'(1);
    end
    if (n > CFG_W'(COLS)) begin
      n = CFG_W'(COLS);
    end
    for (int c = 0; c < COLS; c++) begin
      m[c] = (CFG_W'(c) < n);
    end
    return m;
  endfunction

endpackage

@@ hdl/lgr_cell.sv @@
// One column lane: neighbour count and B3/S23 rule for a single cell.
module lgr_cell
  import lgr_pkg::*;
(
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] down,
  output logic       alive
);

  logic [NCOUNT_W-1:0] ncount;

  always_comb begin
    ncount = NCOUNT_W'(up[0]) + NCOUNT_W'(up[1]) + NCOUNT_W'(up[2])
           + NCOUNT_W'(mid[0]) + NCOUNT_W'(mid[2])
           + NCOUNT_W'(down[0]) + NCOUNT_W'(down[1]) + NCOUNT_W'(down[2]);
    alive = (ncount == BIRTH_COUNT) || ((ncount == SURVIVE_COUNT) && mid[1]);
  end

endmodule

@@ hdl/lgr_row.sv @@
// Row of column lanes and merge of their results into one masked row.
module lgr_row
  import lgr_pkg::*;
(
  input  row_t up,
  input  row_t mid,
  input  row_t down,
  input  row_t mask,
  output row_t next
);

  logic [COLS+1:0] up_p;
  logic [COLS+1:0] mid_p;
  logic [COLS+1:0] down_p;
  row_t            lane_alive;

  assign up_p   = {1'b0, up & mask, 1'b0};
  assign mid_p  = {1'b0, mid & mask, 1'b0};
  assign down_p = {1'b0, down & mask, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    lgr_cell u_cell (
      .up    (up_p[c+2:c]),
      .mid   (mid_p[c+2:c]),
      .down  (down_p[c+2:c]),
      .alive (lane_alive[c])
    );
  end

  assign next = lane_alive & mask;

endmodule

@@ hdl/lgr_queue.sv @@
// Result queue taking up to two results per cycle and releasing one.
module lgr_queue
  import lgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lgr_push_t         push,
  input  logic              pop,
  output lgr_res_t          head,
  output logic [QCNT_W-1:0] count
);

  lgr_res_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.push0) + QPTR_W'(push.push1);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.push0) + QCNT_W'(push.push1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      entry_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      entry_r[wr_ptr_r + QPTR_W'(1)] <= push.res1;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign count = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0)
    else $error("second result pushed without first");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

endmodule

@@ hdl/life_generation_row_stream.sv @@
// Life B3/S23 generation on a row stream: 64 column lanes, two row units, result queue.
// A result is queued when the row that completes it is taken, and offered in queue order.
// Throughput: one row per cycle while the result queue holds at most two entries; a last
// row after a held row yields two results, absorbed by the four-entry result queue.
// Reset (synchronous, rst_n low): held rows and queue cleared, column count set to 64.
module life_generation_row_stream
  import lgr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,   // [6:0] active_columns
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [COLS-1:0]  in_tdata,   // [63:0] row_bits
  input  logic             in_tlast,   // last_row
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [COLS-1:0]  out_tdata,  // [63:0] next_row
  output logic             out_tlast   // end_of_frame
);

  logic [CFG_W-1:0]  active_columns_r;
  row_t              upper_r, upper_nxt;
  row_t              middle_r, middle_nxt;
  logic              held_r, held_nxt;
  row_t              mask;
  row_t              cur;
  row_t              above_next;
  row_t              bottom_next;
  row_t              bottom_up;
  logic              accept;
  logic              pop;
  lgr_push_t         push;
  lgr_res_t          head;
  logic [QCNT_W-1:0] count;

  assign cfg_ready = 1'b1;
  assign mask      = col_mask(active_columns_r);
  assign cur       = in_tdata & mask;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (count <= QCNT_W'(QDEPTH - 2));
  assign bottom_up = held_r ? middle_r : upper_r;

  lgr_row u_row_above (
    .up   (upper_r),
    .mid  (middle_r),
    .down (cur),
    .mask (mask),
    .next (above_next)
  );

  lgr_row u_row_bottom (
    .up   (bottom_up),
    .mid  (cur),
    .down ('0),
    .mask (mask),
    .next (bottom_next)
  );

  always_comb begin
    push.res0 = '{row: bottom_next, eof: 1'b1};
    push.res1 = '{row: bottom_next, eof: 1'b1};
    push.push0 = 1'b0;
    push.push1 = 1'b0;
    if (accept) begin
      if (held_r) begin
        push.res0  = '{row: above_next, eof: 1'b0};
        push.push0 = 1'b1;
        push.push1 = in_tlast;
      end else begin
        push.push0 = in_tlast;
      end
    end
  end

  always_comb begin
    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    held_nxt   = held_r;
    if (accept) begin
      if (in_tlast) begin
        upper_nxt  = '0;
        middle_nxt = '0;
        held_nxt   = 1'b0;
      end else begin
        upper_nxt  = held_r ? middle_r : '0;
        middle_nxt = cur;
        held_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_columns_r <= COLS_RESET;
      upper_r          <= '0;
      middle_r         <= '0;
      held_r           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_columns_r <= cfg_data;
      end
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
      held_r   <= held_nxt;
    end
  end

  assign pop = out_tvalid && out_tready;

  lgr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (count)
  );

  assign out_tvalid = (count != '0);
  assign out_tdata  = head.row;
  assign out_tlast  = head.eof;

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (!held_r && (upper_r == '0) && (middle_r == '0)))
    else $error("held rows not cleared at end of frame");

  a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tlast) |=> held_r)
    else $error("row not held after non-final request");

  a_no_hold_no_above: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (upper_r == '0))
    else $error("upper row set without a held row");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the Life B3/S23 row stream block: directed and random frames.
`timescale 1ns / 100ps

module testbench;
  import lgr_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE     = 4;
  localparam int HOLD_LEN   = 200;

  typedef struct packed {
    row_t row;
    logic eof;
  } gen_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [COLS-1:0]  in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [COLS-1:0]  out_tdata;
  logic             out_tlast;

  gen_row_t         gen_rows_due[$];
  gen_row_t         due;
  row_t             held_above;
  row_t             held_row;
  int               rows_held;
  logic [CFG_W-1:0] col_count;

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  hold_cycles = 0;
  int  stall_left  = 0;
  bit  rx_busy     = 1'b0;
  bit  tx_busy     = 1'b0;

  life_generation_row_stream uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Next-generation model

  function automatic row_t live_mask(input logic [CFG_W-1:0] n_in);
    int n;
    n = n_in;
    if (n < 1) n = 1;
    if (n > COLS) n = COLS;
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic row_t life_next(input row_t up, input row_t mid, input row_t dn);
    row_t m;
    row_t res;
    int   n;
    int   k;
    m   = live_mask(col_count);
    up  = up & m;
    mid = mid & m;
    dn  = dn & m;
    res = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        k = c + d;
        if (k >= 0 && k < COLS) begin
          n += up[k] + dn[k];
          if (d != 0) n += mid[k];
        end
      end
      res[c] = (n == 3) || (n == 2 && mid[c]);
    end
    return res & m;
  endfunction

  function automatic void advance_generation(input row_t r, input logic last);
    row_t cur;
    cur = r & live_mask(col_count);
    if (rows_held == 0) begin
      held_above = '0;
      held_row   = cur;
      rows_held  = 1;
    end else begin
      gen_rows_due.push_back('{row: life_next(held_above, held_row, cur), eof: 1'b0});
      held_above = held_row;
      held_row   = cur;
      rows_held  = 2;
    end
    if (last) begin
      gen_rows_due.push_back('{row: life_next(held_above, held_row, '0), eof: 1'b1});
      held_above = '0;
      held_row   = '0;
      rows_held  = 0;
    end
  endfunction

  // Stimulus helpers

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic row_t random_row();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return '0;
      1: return '1;
      2, 3, 4: return {$urandom, $urandom};
      5, 6, 7: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_columns();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(3);
      3: return CFG_W'(63);
      4, 5: return CFG_W'(64);
      6: return CFG_W'(127);
      7: return CFG_W'($urandom_range(65, 126));
      default: return CFG_W'($urandom_range(2, 62));
    endcase
  endfunction

  task automatic send_row(input row_t r, input logic last);
    int gap;
    gap = (tx_busy && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = r;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    advance_generation(r, last);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (gen_rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_columns(input logic [CFG_W-1:0] v);
    wait_results_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    col_count = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_row(random_row(), i == len - 1);
  endtask

  function automatic int random_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 16);
    return $urandom_range(17, 40);
  endfunction

  // Tests

  task automatic test_single_row_frames();
    write_columns(CFG_W'(64));
    send_row('1, 1'b1);
    send_row(64'h1, 1'b1);
    send_row(64'h8000_0000_0000_0000, 1'b1);
    send_row(64'h7, 1'b1);
  endtask

  task automatic test_frame_edges();
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b1);
  endtask

  task automatic test_column_limits();
    write_columns(CFG_W'(0));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_columns(CFG_W'(1));
    send_row('1, 1'b1);
    write_columns(CFG_W'(3));
    send_row(64'hFFFF_FFFF_FFFF_FFF8, 1'b0);
    send_row(64'h7, 1'b0);
    send_row('1, 1'b1);
    write_columns(CFG_W'(100));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    write_columns(CFG_W'(127));
    send_row(random_row(), 1'b1);
    write_columns(CFG_W'(63));
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
  endtask

  task automatic test_midframe_resize();
    write_columns(CFG_W'(64));
    send_row('1, 1'b0);
    write_columns(CFG_W'(5));
    send_row('1, 1'b1);
  endtask

  task automatic test_receiver_holdoff();
    int sent;
    int n;
    write_columns(CFG_W'(64));
    rx_busy     = 1'b0;
    tx_busy     = 1'b0;
    hold_cycles = HOLD_LEN;
    sent        = 0;
    while (sent < 60) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        send_row(random_row(), i == n - 1);
        sent++;
      end
    end
    wait_results_drained();
  endtask

  task automatic test_random_frames();
    int sent;
    int len;
    for (int phase = 0; phase < 8; phase++) begin
      write_columns(random_columns());
      rx_busy = (phase % 4) != 1;
      tx_busy = (phase % 4) != 2;
      sent    = 0;
      while (sent < 205) begin
        len = random_frame_len();
        send_frame(len);
        sent += len;
      end
    end
  endtask

  // Receiver: random stalls plus requested long hold-offs

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      stall_left  = hold_cycles;
      hold_cycles = 0;
    end
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (rx_busy && $urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      stall_left = pick_pause() - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Result checker

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (gen_rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: next_row %h end_of_frame %b", out_tdata, out_tlast);
      end else begin
        due = gen_rows_due.pop_front();
        if (out_tdata !== due.row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("next_row: expected %h, got %h", due.row, out_tdata);
        end
        if (out_tlast !== due.eof) begin
          mismatches++;
          if (mismatches <= 10)
            $display("end_of_frame: expected %b, got %b", due.eof, out_tlast);
        end
      end
    end
  end

  // Watchdog: cycles with no request moved on any channel

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    held_above = '0;
    held_row   = '0;
    rows_held  = 0;
    col_count  = COLS_RESET;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_single_row_frames();
    test_frame_edges();
    test_column_limits();
    test_midframe_resize();
    test_receiver_holdoff();
    test_random_frames();
    wait_results_drained();
    if (mismatches == 0 && gen_rows_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
